[design/hmc_pkg.sv]
package hmc_pkg;

    // Default sample width, signed Q16.16 at 32 bits.
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Configuration port.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANGE_LOW  = 3'd0,
        REG_RANGE_HIGH = 3'd1,
        REG_TINT_RED   = 3'd2,
        REG_TINT_GREEN = 3'd3,
        REG_TINT_BLUE  = 3'd4,
        REG_OPACITY    = 3'd5
    } t_reg_index;

    localparam logic signed [31:0] RANGE_LOW_RESET  = 32'sd0;
    localparam logic signed [31:0] RANGE_HIGH_RESET = 32'sd65536;
    localparam logic [7:0]         CHAN_RESET       = 8'd255;

    // Position in the range, unsigned Q1.16.
    localparam int T_FRAC_W = 16;
    localparam int T_W      = T_FRAC_W + 1;
    localparam logic [T_W-1:0] T_ONE  = 17'h10000;
    localparam logic [T_W-1:0] T_HALF = 17'h08000;

    // Range divider: one quotient bit per stage.
    localparam int DIV_STEPS = T_FRAC_W;
    localparam int DEN_W     = 33;
    localparam int REM_W     = DEN_W + 1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_INVALID,
        KIND_LOW,
        KIND_HIGH,
        KIND_DIVIDE
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_entry;

    typedef struct packed {
        t_kind               kind;
        logic [REM_W-1:0]    rem;
        logic [DEN_W-1:0]    den;
        logic [T_FRAC_W-1:0] quo;
    } t_div;

    // Color channels.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int NUM_CH   = 3;

    // Blend arithmetic: n = 1785 * (A * 65536 + B * S) + 300 * 65536 * tint,
    // result = n / (1000 * 65536).
    localparam int V_W         = 25;
    localparam int N_W         = 36;
    localparam int P_W         = 20;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = P_W + RECIP_W;
    localparam int RECIP_SHIFT = 30;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam int BLEND_SCALE = 1785;
    localparam int TINT_SCALE  = 300 * 65536;
    localparam logic [RECIP_W-1:0] RECIP_K = 21'd1073742;

    localparam logic [7:0] CHAN_MAX      = 8'd255;
    localparam logic [7:0] INVALID_RED   = 8'd30;
    localparam logic [7:0] INVALID_GREEN = 8'd30;
    localparam logic [7:0] INVALID_BLUE  = 8'd35;

    // Queue, divider stages, blend stages and the output register.
    localparam int RESULT_LATENCY = DIV_STEPS + 4;

    // Ramp offset in hundredths for a channel and a segment of the ramp.
    function automatic logic [6:0] ramp_base(input int ch, input logic seg);
        logic [6:0] a;
        a = 7'd0;
        case (ch)
            CH_RED:   a = seg ? 7'd95 : 7'd15;
            CH_GREEN: a = seg ? 7'd70 : 7'd30;
            CH_BLUE:  a = seg ? 7'd45 : 7'd95;
            default:  a = 7'd0;
        endcase
        return a;
    endfunction

    // Ramp slope in hundredths for a channel and a segment of the ramp.
    function automatic logic signed [6:0] ramp_slope(input int ch, input logic seg);
        logic signed [6:0] b;
        b = 7'sd0;
        case (ch)
            CH_RED:   b = seg ? 7'sd0   : 7'sd30;
            CH_GREEN: b = seg ? -7'sd45 : 7'sd40;
            CH_BLUE:  b = seg ? -7'sd25 : 7'sd0;
            default:  b = 7'sd0;
        endcase
        return b;
    endfunction

endpackage

[design/hmc_front.sv]
module hmc_front #(
    parameter int SAMPLE_WIDTH = hmc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_start,
    input  logic                           i_queue_full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_sample_invalid,
    input  logic signed [31:0]             i_range_low,
    input  logic signed [31:0]             i_range_high,
    output logic                           o_push,
    output hmc_pkg::t_entry                o_entry
);
    import hmc_pkg::*;

    localparam int EXT_W = ((SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32) + 2;

    logic signed [EXT_W-1:0] x_ext;
    logic signed [EXT_W-1:0] lo_ext;
    logic signed [EXT_W-1:0] hi_ext;
    logic signed [EXT_W-1:0] hi_eff;
    logic signed [EXT_W-1:0] num_ext;
    logic signed [EXT_W-1:0] den_ext;
    logic signed [EXT_W-1:0] one_ext;

    assign o_push = i_start && !i_queue_full;

    always_comb begin
        x_ext   = EXT_W'(i_sample);
        lo_ext  = EXT_W'(i_range_low);
        hi_ext  = EXT_W'(i_range_high);
        one_ext = EXT_W'(T_ONE);
        // An empty range counts as a range of one.
        hi_eff  = (i_range_high == i_range_low) ? (lo_ext + one_ext) : hi_ext;

        o_entry.kind = KIND_DIVIDE;
        if (hi_eff > lo_ext) begin
            if (x_ext <= lo_ext) begin
                o_entry.kind = KIND_LOW;
            end else if (x_ext >= hi_eff) begin
                o_entry.kind = KIND_HIGH;
            end
            num_ext = x_ext - lo_ext;
            den_ext = hi_eff - lo_ext;
        end else begin
            if (x_ext >= lo_ext) begin
                o_entry.kind = KIND_LOW;
            end else if (x_ext <= hi_eff) begin
                o_entry.kind = KIND_HIGH;
            end
            num_ext = lo_ext - x_ext;
            den_ext = lo_ext - hi_eff;
        end

        if (i_sample_invalid) begin
            o_entry.kind = KIND_INVALID;
        end
        // Inside the range the numerator stays below the denominator.
        o_entry.num = num_ext[DEN_W-1:0];
        o_entry.den = den_ext[DEN_W-1:0];
    end

endmodule

[design/hmc_queue.sv]
module hmc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hmc_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    output hmc_pkg::t_entry o_entry
);
    import hmc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;
    logic             push_ok;
    logic             pop;

    // The back end drains one beat every cycle it has one.
    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign pop     = o_valid;
    assign push_ok = i_push && !o_full;
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        case ({push_ok, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[design/hmc_back.sv]
module hmc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hmc_pkg::t_entry i_entry,
    input  logic [7:0]      i_tint_red,
    input  logic [7:0]      i_tint_green,
    input  logic [7:0]      i_tint_blue,
    input  logic [7:0]      i_opacity,
    output logic            o_strobe,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [7:0]      o_alpha_out
);
    import hmc_pkg::*;

    // Restoring divider, one quotient bit per stage.
    t_div r_div     [DIV_STEPS];
    logic r_div_vld [DIV_STEPS];
    t_div step_in   [DIV_STEPS];
    logic vld_in    [DIV_STEPS];

    always_comb begin
        step_in[0].kind = i_entry.kind;
        step_in[0].rem  = REM_W'(i_entry.num);
        step_in[0].den  = i_entry.den;
        step_in[0].quo  = '0;
        vld_in[0]       = i_valid;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [REM_W-1:0] rem2;
        logic             ge;

        if (k > 0) begin : g_link
            assign step_in[k] = r_div[k-1];
            assign vld_in[k]  = r_div_vld[k-1];
        end

        assign rem2 = {step_in[k].rem[REM_W-2:0], 1'b0};
        assign ge   = (rem2 >= REM_W'(step_in[k].den));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[k] <= 1'b0;
            end else begin
                r_div_vld[k] <= vld_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[k].kind <= step_in[k].kind;
            r_div[k].den  <= step_in[k].den;
            r_div[k].rem  <= ge ? (rem2 - REM_W'(step_in[k].den)) : rem2;
            r_div[k].quo  <= {step_in[k].quo[T_FRAC_W-2:0], ge};
        end
    end

    // Ramp stage: position, segment and the linear term of each channel.
    t_div                  div_last;
    logic [T_W-1:0]        t_pos;
    logic [T_W-1:0]        t_off;
    logic                  seg;
    logic [T_W-1:0]        s_pos;
    logic signed [V_W-1:0] a_ext [NUM_CH];
    logic signed [V_W-1:0] b_ext [NUM_CH];
    logic signed [V_W-1:0] s_ext;
    logic signed [V_W-1:0] v_next [NUM_CH];
    logic signed [V_W-1:0] r_a_v  [NUM_CH];
    t_kind                 r_a_kind;
    logic                  r_a_vld;

    assign div_last = r_div[DIV_STEPS-1];

    always_comb begin
        case (div_last.kind)
            KIND_LOW:    t_pos = '0;
            KIND_HIGH:   t_pos = T_ONE;
            KIND_DIVIDE: t_pos = {1'b0, div_last.quo};
            default:     t_pos = '0;
        endcase
        seg   = (t_pos >= T_HALF);
        t_off = seg ? (t_pos - T_HALF) : t_pos;
        s_pos = {t_off[T_W-2:0], 1'b0};
        s_ext = V_W'(s_pos);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            a_ext[ch]  = V_W'({ramp_base(ch, seg), 16'h0000});
            b_ext[ch]  = V_W'(ramp_slope(ch, seg));
            v_next[ch] = a_ext[ch] + b_ext[ch] * s_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= r_div_vld[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_kind <= div_last.kind;
        r_a_v    <= v_next;
    end

    // Scale stage: blend with the tint and drop the sixteen fraction bits.
    logic [7:0]            tint  [NUM_CH];
    logic signed [N_W-1:0] v_wide [NUM_CH];
    logic signed [N_W-1:0] t_wide [NUM_CH];
    logic signed [N_W-1:0] n_blend [NUM_CH];
    logic [P_W-1:0]        p_next [NUM_CH];
    logic [P_W-1:0]        r_b_p  [NUM_CH];
    t_kind                 r_b_kind;
    logic                  r_b_vld;

    always_comb begin
        tint[CH_RED]   = i_tint_red;
        tint[CH_GREEN] = i_tint_green;
        tint[CH_BLUE]  = i_tint_blue;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            v_wide[ch]  = N_W'(r_a_v[ch]);
            t_wide[ch]  = N_W'(tint[ch]);
            n_blend[ch] = v_wide[ch] * N_W'(BLEND_SCALE) + t_wide[ch] * N_W'(TINT_SCALE);
            p_next[ch]  = n_blend[ch][N_W-1] ? '0 : n_blend[ch][16 +: P_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_kind <= r_a_kind;
        r_b_p    <= p_next;
    end

    // Output stage: divide by 1000 through a reciprocal, saturate.
    logic [PROD_W-1:0] prod  [NUM_CH];
    logic [Q_W-1:0]    q_val [NUM_CH];
    logic [7:0]        chan  [NUM_CH];
    logic              r_strobe;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;
    logic [7:0]        r_alpha;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            prod[ch]  = PROD_W'(r_b_p[ch]) * PROD_W'(RECIP_K);
            q_val[ch] = prod[ch][RECIP_SHIFT +: Q_W];
            chan[ch]  = (q_val[ch] > Q_W'(CHAN_MAX)) ? CHAN_MAX : q_val[ch][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha <= i_opacity;
        if (r_b_kind == KIND_INVALID) begin
            r_red   <= INVALID_RED;
            r_green <= INVALID_GREEN;
            r_blue  <= INVALID_BLUE;
        end else begin
            r_red   <= chan[CH_RED];
            r_green <= chan[CH_GREEN];
            r_blue  <= chan[CH_BLUE];
        end
    end

    assign o_strobe    = r_strobe;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha_out = r_alpha;

endmodule

[design/heat_map_colorizer_core.sv]
// Heat map colorizer. Each beat on start carries one signed Q16.16 sample and
// an invalid flag; the block answers with one RGBA color per beat, in order.
// A new sample can be taken on every clock, so the sustained rate is one color
// per cycle. The result strobe o_strobe is high for one cycle, and the color is
// registered through the queue, the range divider that works out one bit of
// the position per stage, and the ramp, tint blend and scaling stages. The
// receiver cannot stall, so a color must be taken in the cycle it shows.
// busy is high during reset and whenever the queue is full, which does not
// happen in normal running because the back end drains a beat every cycle.
// Configuration writes land at once and must only be made while no sample is
// in flight.

module heat_map_colorizer_core #(
    parameter int SAMPLE_WIDTH = hmc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample,
    input  logic                             i_sample_invalid,
    input  logic                             i_cfg_we,
    input  logic [hmc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [hmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_strobe,
    output logic [7:0]                       o_red,
    output logic [7:0]                       o_green,
    output logic [7:0]                       o_blue,
    output logic [7:0]                       o_alpha_out
);
    import hmc_pkg::*;

    // Configuration registers. Each write lands on the edge it is given.
    logic signed [31:0] r_range_low;
    logic signed [31:0] r_range_high;
    logic [7:0]         r_tint_red;
    logic [7:0]         r_tint_green;
    logic [7:0]         r_tint_blue;
    logic [7:0]         r_opacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= RANGE_LOW_RESET;
            r_range_high <= RANGE_HIGH_RESET;
            r_tint_red   <= CHAN_RESET;
            r_tint_green <= CHAN_RESET;
            r_tint_blue  <= CHAN_RESET;
            r_opacity    <= CHAN_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_RANGE_LOW:  r_range_low  <= i_cfg_data[31:0];
                REG_RANGE_HIGH: r_range_high <= i_cfg_data[31:0];
                REG_TINT_RED:   r_tint_red   <= i_cfg_data[7:0];
                REG_TINT_GREEN: r_tint_green <= i_cfg_data[7:0];
                REG_TINT_BLUE:  r_tint_blue  <= i_cfg_data[7:0];
                REG_OPACITY:    r_opacity    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The front end classifies each sample: invalid, clamped to either end of
    // the range, or in range with a numerator and denominator for the divider.
    logic   push;
    logic   queue_full;
    logic   queue_valid;
    t_entry front_entry;
    t_entry queue_entry;

    assign busy = !i_rst_n || queue_full;

    hmc_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_start         (start),
        .i_queue_full    (queue_full),
        .i_sample        (i_sample),
        .i_sample_invalid(i_sample_invalid),
        .i_range_low     (r_range_low),
        .i_range_high    (r_range_high),
        .o_push          (push),
        .o_entry         (front_entry)
    );

    // The queue parts the front end from the arithmetic pipeline.
    hmc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(front_entry),
        .o_full (queue_full),
        .o_valid(queue_valid),
        .o_entry(queue_entry)
    );

    // The back end divides, runs the ramp, blends with the tint and registers
    // the color onto the result ports.
    hmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_entry     (queue_entry),
        .i_tint_red  (r_tint_red),
        .i_tint_green(r_tint_green),
        .i_tint_blue (r_tint_blue),
        .i_opacity   (r_opacity),
        .o_strobe    (o_strobe),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha_out (o_alpha_out)
    );

endmodule

[design/hmc_checker.sv]
module hmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_sample_invalid,
    input logic       o_strobe,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);
    import hmc_pkg::*;

    logic accept;

    assign accept = start && !busy;

    // Every color comes from a beat taken a fixed number of edges before.
    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, RESULT_LATENCY))
        else $error("result strobe without a matching sample beat");

    // Every sample beat yields a color after the fixed latency.
    a_beat_yields_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##RESULT_LATENCY o_strobe)
        else $error("sample beat produced no color");

    // An invalid sample gives the fixed dark color.
    a_invalid_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sample_invalid) |-> ##RESULT_LATENCY
            (o_strobe && o_red == INVALID_RED && o_green == INVALID_GREEN
             && o_blue == INVALID_BLUE))
        else $error("invalid sample did not give the fixed color");

    // The pipeline drains every cycle, so the queue never fills.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised outside reset");

endmodule

bind heat_map_colorizer_core hmc_checker u_hmc_checker (.*);

[tb/tb_heat_map_colorizer_core.sv]
`timescale 1ns / 1ps

// Self-checking bench for the heat map colorizer. Each beat on start carries
// one Q16.16 sample and an invalid flag, and every beat comes back as exactly
// one RGBA color, in order. The bench keeps its own copy of the six
// configuration registers and works out each color when the beat is taken.
// The color goes into a FIFO, and a monitor on o_strobe compares every color
// that arrives with the oldest entry in that FIFO.
module tb_heat_map_colorizer_core;
    import hmc_pkg::*;

    // Indexes past the last register. The block must ignore writes to them.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Chance, in percent, that the sender leaves a cycle empty before a beat.
    localparam int GAP_NONE  = 0;
    localparam int GAP_HEAVY = 73;
    localparam int GAP_LIGHT = 12;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 119;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_color;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    // One row of the directed table: either a sample beat or a register write.
    // A beat whose color is obvious carries it as a literal; any other beat is
    // checked against the color model below.
    typedef struct packed {
        t_row_kind              kind;
        logic [31:0]            value;
        logic                   invalid;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
        logic                   has_literal;
        t_color                 want;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic signed [31:0]            i_sample;
    logic                          i_sample_invalid;
    logic                          i_cfg_we;
    logic [CFG_INDEX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          o_strobe;
    logic [7:0]                    o_red;
    logic [7:0]                    o_green;
    logic [7:0]                    o_blue;
    logic [7:0]                    o_alpha_out;

    // Shadow copy of the configuration registers.
    logic signed [31:0] cfg_low;
    logic signed [31:0] cfg_high;
    logic [7:0]         cfg_tint_red;
    logic [7:0]         cfg_tint_green;
    logic [7:0]         cfg_tint_blue;
    logic [7:0]         cfg_opacity;

    t_color pending_colors[$];
    t_row   plan[$];
    int     gap_pct;
    int     mismatch_count;
    int     cycle_count;

    heat_map_colorizer_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sample         (i_sample),
        .i_sample_invalid (i_sample_invalid),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha_out      (o_alpha_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // One channel of the ramp blended with the tint. The ramp offset a and the
    // slope b are in hundredths, s is the position within the segment in Q1.16.
    // Everything is kept as one exact fraction over 1000 * 65536, so the
    // truncation happens once, at the end.
    function automatic logic [7:0] blend_tint(input longint a, input longint b,
                                              input longint s, input logic [7:0] tint);
        longint n;
        longint q;
        n = 1785 * (a * 65536 + b * s) + 300 * longint'(tint) * 65536;
        if (n < 0)
            return 8'd0;
        q = n / 65536000;
        if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    function automatic t_color predict_color(input logic [31:0] value, input logic invalid);
        t_color c;
        longint x;
        longint lo;
        longint hi;
        longint t;
        longint s;
        c.alpha = cfg_opacity;
        if (invalid) begin
            c.red   = INVALID_RED;
            c.green = INVALID_GREEN;
            c.blue  = INVALID_BLUE;
            return c;
        end
        x  = longint'($signed(value));
        lo = longint'(cfg_low);
        hi = longint'(cfg_high);
        // A range of zero width stands for a range of 1.0 above the low bound.
        if (hi == lo)
            hi = lo + 65536;
        // Position in the range as Q1.16, rounded toward zero. A reversed
        // range maps the low bound to 0 just the same, counting downward.
        if (hi > lo) begin
            if (x <= lo)
                t = 0;
            else if (x >= hi)
                t = 65536;
            else
                t = ((x - lo) * 65536) / (hi - lo);
        end else begin
            if (x >= lo)
                t = 0;
            else if (x <= hi)
                t = 65536;
            else
                t = ((lo - x) * 65536) / (lo - hi);
        end
        // Cold half goes blue to pale blue, hot half orange to red.
        if (t < 32768) begin
            s = t * 2;
            c.red   = blend_tint(15, 30, s, cfg_tint_red);
            c.green = blend_tint(30, 40, s, cfg_tint_green);
            c.blue  = blend_tint(95, 0, s, cfg_tint_blue);
        end else begin
            s = (t - 32768) * 2;
            c.red   = blend_tint(95, 0, s, cfg_tint_red);
            c.green = blend_tint(70, -45, s, cfg_tint_green);
            c.blue  = blend_tint(45, -25, s, cfg_tint_blue);
        end
        return c;
    endfunction

    // Clamps a wide value into the signed 32-bit range of a sample or bound.
    function automatic logic [31:0] clamp_q16(input longint x);
        if (x > 64'sd2147483647)
            x = 64'sd2147483647;
        if (x < -64'sd2147483648)
            x = -64'sd2147483648;
        return x[31:0];
    endfunction

    // Tint and opacity values per phase: random, all zero, or all full scale.
    function automatic logic [7:0] pick_byte(input int phase);
        case (phase % 4)
            1:       return 8'd0;
            2:       return CHAN_MAX;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_row item_row(input logic [31:0] value, input logic invalid);
        t_row r;
        r = '0;
        r.kind    = ROW_ITEM;
        r.value   = value;
        r.invalid = invalid;
        return r;
    endfunction

    function automatic t_row known_row(input logic [31:0] value, input logic invalid,
                                       input t_color want);
        t_row r;
        r = item_row(value, invalid);
        r.has_literal = 1'b1;
        r.want        = want;
        return r;
    endfunction

    function automatic t_row write_row(input logic [CFG_INDEX_W-1:0] index,
                                       input logic [31:0] data);
        t_row r;
        r = '0;
        r.kind  = ROW_WRITE;
        r.index = index;
        r.data  = data;
        return r;
    endfunction

    // Every mismatch is counted, and the run carries on to its normal end.
    function automatic void check_channel(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Drives one register write. The enable stays high so that writes can go
    // back to back; the caller lowers it after the last write of a batch.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            REG_RANGE_LOW:  cfg_low        = data;
            REG_RANGE_HIGH: cfg_high       = data;
            REG_TINT_RED:   cfg_tint_red   = data[7:0];
            REG_TINT_GREEN: cfg_tint_green = data[7:0];
            REG_TINT_BLUE:  cfg_tint_blue  = data[7:0];
            REG_OPACITY:    cfg_opacity    = data[7:0];
            default:        ;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one beat, after a random number of empty cycles, and holds it
    // until the block takes it. The expected color is queued at acceptance.
    task automatic send_sample(input logic [31:0] value, input logic invalid,
                               input t_color want);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_sample         <= value;
        i_sample_invalid <= invalid;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_colors.push_back(want);
    endtask

    // Stops sending and waits until every color in flight has come back.
    // Since every beat yields a color, the block is idle at that point.
    task automatic drain_colors();
        start <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic configure_phase(input int phase);
        logic [31:0] low;
        logic [31:0] high;
        longint      span;
        low  = $urandom();
        span = longint'($urandom_range(1, 1 << 20));
        case (phase % 6)
            0: high = $urandom();
            1: high = clamp_q16(longint'($signed(low)) + span);
            2: high = low;
            3: high = clamp_q16(longint'($signed(low)) - span);
            4: begin
                low  = 32'h8000_0000;
                high = 32'h7FFF_FFFF;
            end
            default: begin
                low  = 32'h7FFF_FFFF;
                high = 32'h8000_0000;
            end
        endcase
        write_reg(REG_RANGE_LOW, low);
        write_reg(REG_RANGE_HIGH, high);
        // Upper data bits are noise; only the low byte lands in the register.
        write_reg(REG_TINT_RED, {24'($urandom()), pick_byte(phase)});
        write_reg(REG_TINT_GREEN, {24'($urandom()), pick_byte(phase)});
        write_reg(REG_TINT_BLUE, {24'($urandom()), pick_byte(phase)});
        write_reg(REG_OPACITY, {24'($urandom()), pick_byte(phase + 1)});
        i_cfg_we <= 1'b0;
    endtask

    // Most random samples land inside the configured range so the ramp and
    // the divider get exercised; the rest are bounds, noise and invalid beats.
    task automatic next_random_item(output logic [31:0] value, output logic invalid);
        longint lo;
        longint hi;
        int     pick;
        lo   = longint'(cfg_low);
        hi   = longint'(cfg_high);
        if (hi == lo)
            hi = lo + 65536;
        pick    = $urandom_range(99);
        invalid = 1'b0;
        if (pick < 8) begin
            invalid = 1'b1;
            value   = $urandom();
        end else if (pick < 20) begin
            value = $urandom();
        end else if (pick < 30) begin
            case ($urandom_range(3))
                0:       value = clamp_q16(lo);
                1:       value = clamp_q16(hi);
                2:       value = clamp_q16(lo + 1);
                default: value = clamp_q16(hi - 1);
            endcase
        end else begin
            value = clamp_q16(lo + ((hi - lo) * longint'($urandom_range(65536))) / 65536);
        end
    endtask

    // Result side: the receiver cannot stall, so every strobe is one color.
    always @(posedge i_clk) begin : color_monitor
        t_color want;
        if (i_rst_n && o_strobe) begin
            if (pending_colors.size() == 0) begin
                $error("color with no beat waiting: %0d %0d %0d %0d",
                       o_red, o_green, o_blue, o_alpha_out);
                mismatch_count++;
            end else begin
                want = pending_colors.pop_front();
                check_channel("red", want.red, o_red);
                check_channel("green", want.green, o_green);
                check_channel("blue", want.blue, o_blue);
                check_channel("alpha_out", want.alpha, o_alpha_out);
            end
        end
    end

    // Hard stop in case the block hangs or stops answering.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] value;
        logic        invalid;
        int          pause_at;
        start            <= 1'b0;
        i_rst_n          <= 1'b0;
        i_sample         <= '0;
        i_sample_invalid <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        mismatch_count = 0;
        gap_pct        = GAP_NONE;
        cfg_low        = RANGE_LOW_RESET;
        cfg_high       = RANGE_HIGH_RESET;
        cfg_tint_red   = CHAN_RESET;
        cfg_tint_green = CHAN_RESET;
        cfg_tint_blue  = CHAN_RESET;
        cfg_opacity    = CHAN_RESET;

        // Directed part. Writes to the two unused indexes must leave the reset
        // values alone, so the literal colors that follow still hold.
        plan.push_back(write_row(REG_UNMAPPED_LO, 32'hFFFF_FFFF));
        plan.push_back(write_row(REG_UNMAPPED_HI, 32'hFFFF_FFFF));
        plan.push_back(known_row(32'h0000_0000, 1'b0, '{8'd103, 8'd130, 8'd246, 8'd255}));
        plan.push_back(known_row(32'h0001_0000, 1'b0, '{8'd246, 8'd121, 8'd112, 8'd255}));
        plan.push_back(known_row(32'h0000_8000, 1'b0, '{8'd246, 8'd201, 8'd156, 8'd255}));
        plan.push_back(item_row(32'h0000_7FFF, 1'b0));
        plan.push_back(item_row(32'h0000_4000, 1'b0));
        // Samples far outside the range saturate to the ends of the ramp.
        plan.push_back(known_row(32'h7FFF_FFFF, 1'b0, '{8'd246, 8'd121, 8'd112, 8'd255}));
        plan.push_back(known_row(32'h8000_0000, 1'b0, '{8'd103, 8'd130, 8'd246, 8'd255}));
        // An invalid beat gives the fixed color whatever the sample holds.
        plan.push_back(known_row(32'h5555_AAAA, 1'b1, '{8'd30, 8'd30, 8'd35, 8'd255}));
        plan.push_back(known_row(32'hAAAA_5555, 1'b1, '{8'd30, 8'd30, 8'd35, 8'd255}));
        plan.push_back(write_row(REG_OPACITY, 32'h0000_0000));
        plan.push_back(write_row(REG_TINT_RED, 32'h0000_0000));
        plan.push_back(write_row(REG_TINT_GREEN, 32'h0000_0000));
        plan.push_back(write_row(REG_TINT_BLUE, 32'h0000_0000));
        plan.push_back(known_row(32'h0000_0000, 1'b1, '{8'd30, 8'd30, 8'd35, 8'd0}));
        plan.push_back(item_row(32'h0000_0000, 1'b0));
        plan.push_back(item_row(32'h0001_0000, 1'b0));
        plan.push_back(item_row(32'h0000_C000, 1'b0));
        // Zero-width range at the top of the scale: the implied high bound
        // lies past the largest sample.
        plan.push_back(write_row(REG_RANGE_LOW, 32'h7FFF_FFFF));
        plan.push_back(write_row(REG_RANGE_HIGH, 32'h7FFF_FFFF));
        plan.push_back(item_row(32'h7FFF_FFFF, 1'b0));
        plan.push_back(item_row(32'h0000_0000, 1'b0));
        // Widest reversed range.
        plan.push_back(write_row(REG_RANGE_HIGH, 32'h8000_0000));
        plan.push_back(item_row(32'h0000_0000, 1'b0));
        plan.push_back(item_row(32'hFFFF_FFFF, 1'b0));
        plan.push_back(item_row(32'h8000_0001, 1'b0));
        plan.push_back(item_row(32'h8000_0000, 1'b0));
        plan.push_back(item_row(32'hC000_0000, 1'b0));
        // Zero-width range at the bottom of the scale.
        plan.push_back(write_row(REG_RANGE_LOW, 32'h8000_0000));
        plan.push_back(item_row(32'h8000_8000, 1'b0));
        plan.push_back(item_row(32'h7FFF_FFFF, 1'b0));
        plan.push_back(write_row(REG_TINT_RED, 32'hFFFF_FFFF));
        plan.push_back(write_row(REG_TINT_GREEN, 32'hFFFF_FFFF));
        plan.push_back(write_row(REG_TINT_BLUE, 32'hFFFF_FFFF));
        plan.push_back(write_row(REG_OPACITY, 32'h1234_5680));
        plan.push_back(item_row(32'h8000_4000, 1'b0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (i == 0 || plan[i-1].kind == ROW_ITEM)
                    drain_colors();
                write_reg(plan[i].index, plan[i].data);
                if (i == plan.size() - 1 || plan[i+1].kind == ROW_ITEM)
                    i_cfg_we <= 1'b0;
            end else begin
                send_sample(plan[i].value, plan[i].invalid,
                            plan[i].has_literal ? plan[i].want
                                                : predict_color(plan[i].value,
                                                                plan[i].invalid));
            end
        end

        // Random part: each phase drains, reprograms every register and then
        // streams beats with its own sender gap rate. Somewhere in each phase,
        // after at least one beat, the sender stops until the pipeline is
        // empty, then resumes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_colors();
            configure_phase(phase);
            case (phase % 3)
                0:       gap_pct = GAP_NONE;
                1:       gap_pct = GAP_HEAVY;
                default: gap_pct = GAP_LIGHT;
            endcase
            pause_at = $urandom_range(ITEMS_PER_PHASE - 1, 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == pause_at)
                    drain_colors();
                next_random_item(value, invalid);
                send_sample(value, invalid, predict_color(value, invalid));
            end
        end

        // Let the last colors come back, then watch a little longer for strays.
        drain_colors();
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_colors.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
